// File: src/u8sd_pkg.sv
// shared types, constants and byte-class helpers for the utf-8 stream decoder
// no dependencies; used by u8sd_ctrl, u8sd_dpath and utf8_stream_decoder
package u8sd_pkg;

	// replacement character given for malformed or cut-off sequences
	localparam logic [20:0] REPL_CP = 21'h00FFFD;

	// byte class masks and patterns
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_PAT  = 8'h80;
	localparam logic [7:0] ASCII_LIM = 8'h80;
	localparam logic [7:0] LEAD2_MSK = 8'hE0;
	localparam logic [7:0] LEAD2_PAT = 8'hC0;
	localparam logic [7:0] LEAD3_MSK = 8'hF0;
	localparam logic [7:0] LEAD3_PAT = 8'hE0;
	localparam logic [7:0] LEAD4_MSK = 8'hF8;
	localparam logic [7:0] LEAD4_PAT = 8'hF0;

	// window of held bytes plus the new byte
	localparam int unsigned WIN_DEPTH = 4;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // take the input request into the window
		logic step;   // resolve one sequence at the scan pointer
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic emit;     // current step gives a result
		logic finish;   // current step ends the scan of this window
		logic out_free; // output register can take a result this cycle
	} status_t;

	// sequence length from the lead byte, 0 for stray continuation or invalid lead
	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		if (b < ASCII_LIM)
			len = 3'd1;
		else if ((b & LEAD2_MSK) == LEAD2_PAT)
			len = 3'd2;
		else if ((b & LEAD3_MSK) == LEAD3_PAT)
			len = 3'd3;
		else if ((b & LEAD4_MSK) == LEAD4_PAT)
			len = 3'd4;
		return len;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return (b & CONT_MASK) == CONT_PAT;
	endfunction

endpackage

// File: src/utf8_stream_decoder.sv
// utf-8 stream decoder: bytes in, code points out
// top level; depends on u8sd_pkg, u8sd_ctrl and u8sd_dpath
//
// Usage: the input channel (in_valid/in_ready) carries one byte of a UTF-8
// string per request with end_of_string marking its final byte. The output
// channel (out_valid/out_ready) carries code points, 0xFFFD with
// is_replacement for malformed or cut-off sequences. run_last marks the last
// result caused by an input byte, string_done the last result of a string.
// A byte that only extends an unfinished sequence gives no result.
// Operation: a byte is taken, then the decoder resolves one sequence per
// cycle from a four-byte window (held bytes plus the new byte), holding
// while a result has no room in the output register. A byte that leaves
// an unfinished sequence held takes a further scan step with no result;
// in_ready is high again after the scan ends. The first result is
// registered by the first scan step after the byte is taken.
// The sequencer takes no new byte until the scan of the current byte ends.
// The last result waits in the output register while the next byte is
// taken. While the output register is full and out_ready is low, the scan
// holds with its result pending and takes no new byte. Reset clears the
// held bytes and the output register; the next byte starts a new string.
module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [20:0] code_point,
	output logic        is_replacement,
	output logic        run_last,
	output logic        string_done
);

	u8sd_pkg::cmd_t    cmd;
	u8sd_pkg::status_t status;

	// sequencer
	u8sd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// window, decode and output register
	u8sd_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.data_byte      (data_byte),
		.end_of_string  (end_of_string),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.code_point     (code_point),
		.is_replacement (is_replacement),
		.run_last       (run_last),
		.string_done    (string_done)
	);

endmodule

// File: src/u8sd_ctrl.sv
// controller state machine for the utf-8 stream decoder
// depends on u8sd_pkg; drives u8sd_dpath through cmd_t, reads status_t
module u8sd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  u8sd_pkg::status_t  status,
	output u8sd_pkg::cmd_t     cmd
);

	u8sd_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= u8sd_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			u8sd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = u8sd_pkg::ST_SCAN;
				end
			end
			u8sd_pkg::ST_SCAN: begin
				// a step that gives a result waits for room in the output register
				if (!status.emit || status.out_free) begin
					cmd.step = 1'b1;
					if (status.finish)
						state_d = u8sd_pkg::ST_IDLE;
				end
			end
			default: state_d = u8sd_pkg::ST_IDLE;
		endcase
	end

endmodule

// File: src/u8sd_dpath.sv
// datapath of the utf-8 stream decoder: byte window, scan pointer, decode, output register
// depends on u8sd_pkg; commanded by u8sd_ctrl
module u8sd_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  u8sd_pkg::cmd_t     cmd,
	output u8sd_pkg::status_t  status,
	input  logic [7:0]         data_byte,
	input  logic               end_of_string,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [20:0]        code_point,
	output logic               is_replacement,
	output logic               run_last,
	output logic               string_done
);

	// window and scan state
	logic [7:0]  win_q [u8sd_pkg::WIN_DEPTH];
	logic [2:0]  cnt_q;
	logic [1:0]  ptr_q;
	logic        eos_q;

	// output register
	logic        out_valid_q;
	logic [20:0] cp_q;
	logic        err_q;
	logic        last_q;
	logic        done_q;

	// decode signals
	logic [7:0]  lead, c1, c2, c3, la_byte;
	logic [2:0]  len, la_len, p_end, next_p;
	logic        short_seq, conts_ok, la_short, last;
	logic        res_err;
	logic [20:0] cp_build, res_cp;

	// decode the sequence at the scan pointer
	always_comb begin
		lead      = win_q[ptr_q];
		c1        = win_q[ptr_q + 2'd1];
		c2        = win_q[ptr_q + 2'd2];
		c3        = win_q[ptr_q + 2'd3];
		len       = u8sd_pkg::seq_len(lead);
		p_end     = {1'b0, ptr_q} + len;
		short_seq = (len != 3'd0) && (p_end > cnt_q);
		conts_ok  = (len < 3'd2 || u8sd_pkg::is_cont(c1)) &&
		            (len < 3'd3 || u8sd_pkg::is_cont(c2)) &&
		            (len < 3'd4 || u8sd_pkg::is_cont(c3));
		unique case (len)
			3'd1:    cp_build = {13'd0, lead};
			3'd2:    cp_build = {10'd0, lead[4:0], c1[5:0]};
			3'd3:    cp_build = {5'd0, lead[3:0], c1[5:0], c2[5:0]};
			3'd4:    cp_build = {lead[2:0], c1[5:0], c2[5:0], c3[5:0]};
			default: cp_build = '0;
		endcase
		res_err = (len == 3'd0) || short_seq || !conts_ok;
		res_cp  = res_err ? u8sd_pkg::REPL_CP : cp_build;
		// a bad continuation consumes only the lead
		next_p  = (len != 3'd0 && conts_ok) ? p_end : ({1'b0, ptr_q} + 3'd1);
	end

	// look ahead one sequence to know whether this result ends the request
	always_comb begin
		la_byte  = win_q[next_p[1:0]];
		la_len   = u8sd_pkg::seq_len(la_byte);
		la_short = (la_len != 3'd0) &&
		           (({1'b0, next_p} + {1'b0, la_len}) > {1'b0, cnt_q});
		last     = short_seq || (next_p == cnt_q) || (!eos_q && la_short);
	end

	// status to the controller
	always_comb begin
		status.emit     = !short_seq || eos_q;
		status.finish   = short_seq || (next_p == cnt_q);
		status.out_free = !out_valid_q || out_ready;
	end

	// window count, scan pointer and end-of-string flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
			eos_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q <= cnt_q + 3'd1;
			ptr_q <= '0;
			eos_q <= end_of_string;
		end else if (cmd.step) begin
			if (status.finish) begin
				ptr_q <= '0;
				// an unfinished sequence stays held unless the string ends
				if (short_seq && !eos_q)
					cnt_q <= cnt_q - {1'b0, ptr_q};
				else
					cnt_q <= '0;
			end else begin
				ptr_q <= next_p[1:0];
			end
		end
	end

	// window bytes: append on load, move held bytes to the front on hold
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_q[cnt_q[1:0]] <= data_byte;
		end else if (cmd.step && status.finish && short_seq && !eos_q) begin
			for (int i = 0; i < u8sd_pkg::WIN_DEPTH - 1; i++)
				win_q[i] <= win_q[ptr_q + 2'(i)];
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.step && status.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.step && status.emit) begin
			cp_q   <= res_cp;
			err_q  <= res_err;
			last_q <= last;
			done_q <= last && eos_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign code_point     = cp_q;
	assign is_replacement = err_q;
	assign run_last       = last_q;
	assign string_done    = done_q;

	// window never holds more than four bytes
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("window count out of range");

	// an error result always carries the replacement character
	a_err_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q) |-> (cp_q == u8sd_pkg::REPL_CP))
		else $error("error result without replacement code point");

	// end of string leaves nothing held
	a_eos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && status.finish && eos_q) |=> (cnt_q == 3'd0))
		else $error("bytes held across end of string");

	// string_done only on the last result of a request
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> last_q)
		else $error("string_done without run_last");

	// a result is never overwritten while stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && status.emit) |-> (!out_valid_q || out_ready))
		else $error("result overwritten while output stalled");

endmodule

// File: dv/utf8_stream_decoder_tb.sv
// self-checking testbench for utf8_stream_decoder: byte requests in, code points out
// depends on u8sd_pkg and utf8_stream_decoder; holds its own decoder prediction
// in a scoreboard class and drives both valid/ready channels with random idling
module utf8_stream_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS   = 350;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned TAIL_CYCLES    = 20;

	// directed bytes, bit 8 marks the last byte of a string
	localparam int unsigned DIRECTED_N = 26;
	localparam logic [8:0] DIRECTED [DIRECTED_N] = '{
		9'h000, 9'h17F,                 // ascii extremes
		9'h0E2, 9'h082, 9'h0AC,         // three-byte sequence
		9'h0F0, 9'h09F, 9'h098, 9'h180, // four-byte sequence
		9'h0EF, 9'h0BF, 9'h0BD,         // well-formed U+FFFD, not an error
		9'h080,                         // stray continuation
		9'h0FF,                         // invalid lead
		9'h0F0, 9'h080, 9'h080, 9'h141, // bad continuation, rescan gives four results
		9'h0F4, 9'h090, 9'h080, 9'h080, // above U+10FFFF, no range check
		9'h0C0, 9'h080,                 // overlong form, no check
		9'h0F0, 9'h141                  // cut off by end of string, bad byte dropped
	};

	typedef enum int unsigned {
		TK_ASCII, TK_TWO, TK_THREE, TK_FOUR, TK_STRAY, TK_BAD_LEAD, TK_BAD_CONT,
		TK_SHORT, TK_NOISE
	} token_kind_t;

	typedef enum int unsigned {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        is_replacement;
		logic        run_last;
		logic        string_done;
	} cp_result_t;

	// decoder prediction and in-order result check
	class cp_scoreboard;
		logic [7:0]  held [3];
		int unsigned held_n;
		cp_result_t  expected_q [$];
		int unsigned errors;

		function new();
			held_n = 0;
			errors = 0;
		endfunction

		function int unsigned lead_len(logic [7:0] b);
			casez (b)
				8'b0???????: return 1;
				8'b110?????: return 2;
				8'b1110????: return 3;
				8'b11110???: return 4;
				default:     return 0;
			endcase
		endfunction

		function logic [20:0] lead_bits(logic [7:0] b, int unsigned len);
			case (len)
				1:       return 21'(b);
				2:       return 21'(b[4:0]);
				3:       return 21'(b[3:0]);
				default: return 21'(b[2:0]);
			endcase
		endfunction

		// resolve the window of held bytes plus the new byte
		function void note_input(logic [7:0] b, logic eos);
			logic [7:0]  win [4];
			logic [20:0] cps [4];
			logic        reps [4];
			logic [20:0] cp;
			cp_result_t  r;
			int unsigned n, p, len, k, i;
			bit          ok;
			n = 0;
			p = 0;
			k = 0;
			for (i = 0; i < held_n; i++) begin
				win[n] = held[i];
				n++;
			end
			win[n] = b;
			n++;
			held_n = 0;
			while (p < n) begin
				len = lead_len(win[p]);
				if (len == 0) begin
					cps[k] = u8sd_pkg::REPL_CP;
					reps[k] = 1'b1;
					k++;
					p++;
				end else if (p + len > n) begin
					// unfinished: error at end of string, else keep it for later
					if (eos) begin
						cps[k] = u8sd_pkg::REPL_CP;
						reps[k] = 1'b1;
						k++;
					end else begin
						for (i = 0; p + i < n; i++)
							held[i] = win[p + i];
						held_n = n - p;
					end
					break;
				end else begin
					cp = lead_bits(win[p], len);
					ok = 1'b1;
					for (i = 1; i < len; i++) begin
						if (win[p + i][7:6] != 2'b10) begin
							ok = 1'b0;
							break;
						end
						cp = (cp << 6) | 21'(win[p + i][5:0]);
					end
					// a bad continuation consumes only the lead
					if (ok) begin
						cps[k] = cp;
						reps[k] = 1'b0;
						p += len;
					end else begin
						cps[k] = u8sd_pkg::REPL_CP;
						reps[k] = 1'b1;
						p++;
					end
					k++;
				end
			end
			if (eos)
				held_n = 0;
			for (i = 0; i < k; i++) begin
				r.code_point = cps[i];
				r.is_replacement = reps[i];
				r.run_last = (i == k - 1);
				r.string_done = eos && (i == k - 1);
				expected_q.insert(expected_q.size(), r);
			end
		endfunction

		function void check(cp_result_t got);
			cp_result_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result: code_point %h", got.code_point);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.code_point !== want.code_point) begin
				$error("code_point: expected %h, got %h", want.code_point, got.code_point);
				errors++;
			end
			if (got.is_replacement !== want.is_replacement) begin
				$error("is_replacement: expected %b, got %b",
					want.is_replacement, got.is_replacement);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %b, got %b", want.run_last, got.run_last);
				errors++;
			end
			if (got.string_done !== want.string_done) begin
				$error("string_done: expected %b, got %b", want.string_done, got.string_done);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        end_of_string;
	logic        out_valid;
	logic        out_ready;
	logic [20:0] code_point;
	logic        is_replacement;
	logic        run_last;
	logic        string_done;

	cp_scoreboard sb = new();
	logic [7:0]   text_q [$];
	int unsigned  sent;
	int unsigned  burst_left;

	utf8_stream_decoder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_string  (end_of_string),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.code_point     (code_point),
		.is_replacement (is_replacement),
		.run_last       (run_last),
		.string_done    (string_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// append one byte to the string being built
	function void append_text(logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endfunction

	// byte makers for the random strings
	function logic [7:0] cont_byte();
		return {2'b10, 6'($urandom_range(0, 63))};
	endfunction

	function logic [7:0] non_cont_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b[7:6] == 2'b10) begin
			if ($urandom_range(0, 1) != 0)
				b[7] = 1'b0;
			else
				b[6] = 1'b1;
		end
		return b;
	endfunction

	function logic [7:0] lead_byte(int unsigned len);
		case (len)
			1:       return {1'b0, 7'($urandom_range(0, 127))};
			2:       return {3'b110, 5'($urandom_range(0, 31))};
			3:       return {4'b1110, 4'($urandom_range(0, 15))};
			default: return {5'b11110, 3'($urandom_range(0, 7))};
		endcase
	endfunction

	// lead plus continuations, one of them broken when bad_at is nonzero
	function void add_seq(int unsigned len, int unsigned bad_at);
		append_text(lead_byte(len));
		for (int unsigned i = 1; i < len; i++)
			append_text(i == bad_at ? non_cont_byte() : cont_byte());
	endfunction

	function void add_short();
		int unsigned len;
		len = $urandom_range(2, 4);
		append_text(lead_byte(len));
		repeat ($urandom_range(0, len - 2))
			append_text(cont_byte());
	endfunction

	function token_kind_t pick_token();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 25) return TK_ASCII;
		if (roll < 40) return TK_TWO;
		if (roll < 55) return TK_THREE;
		if (roll < 68) return TK_FOUR;
		if (roll < 73) return TK_STRAY;
		if (roll < 78) return TK_BAD_LEAD;
		if (roll < 88) return TK_BAD_CONT;
		if (roll < 94) return TK_SHORT;
		return TK_NOISE;
	endfunction

	function void build_string();
		int unsigned len;
		text_q.delete();
		repeat ($urandom_range(1, 6)) begin
			case (pick_token())
				TK_ASCII:    add_seq(1, 0);
				TK_TWO:      add_seq(2, 0);
				TK_THREE:    add_seq(3, 0);
				TK_FOUR:     add_seq(4, 0);
				TK_STRAY:    append_text(cont_byte());
				TK_BAD_LEAD: append_text({5'b11111, 3'($urandom_range(0, 7))});
				TK_BAD_CONT: begin
					len = $urandom_range(2, 4);
					add_seq(len, $urandom_range(1, len - 1));
				end
				TK_SHORT:    add_short();
				default:     append_text(8'($urandom_range(0, 255)));
			endcase
		end
		// sometimes the string ends in the middle of a sequence
		if ($urandom_range(0, 4) == 0)
			add_short();
	endfunction

	// sender idle for the gap given by n, payload scrambled while invalid
	task automatic idle(int unsigned n);
		in_valid <= 1'b0;
		data_byte <= 8'($urandom_range(0, 255));
		end_of_string <= 1'($urandom_range(0, 1));
		repeat (n) @(negedge clk);
	endtask

	// hold off until every expected result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.expected_q.size() != 0)
			@(negedge clk);
	endtask

	// one byte request, in bursts with random gaps between them
	task automatic send_byte(logic [7:0] b, logic eos);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0)
				idle(gap);
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_string <= eos;
		do @(posedge clk); while (!in_ready);
		sb.note_input(b, eos);
		sent++;
		@(negedge clk);
	endtask

	// stimulus
	initial begin
		int unsigned random_start;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		end_of_string = 1'b0;
		sent = 0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int unsigned i = 0; i < DIRECTED_N; i++)
			send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		drain();

		random_start = sent;
		while (sent - random_start < RANDOM_ITEMS) begin
			build_string();
			foreach (text_q[i])
				send_byte(text_q[i], i == text_q.size() - 1);
			if ($urandom_range(0, 11) == 0)
				drain();
		end

		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("utf8_stream_decoder_tb: done, clean");
		else
			$display("utf8_stream_decoder_tb: done, errors");
		$finish;
	end

	// receiver stalls, switching between open, random and sparse spans
	initial begin
		rx_mode_t mode;
		out_ready = 1'b0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 2));
			repeat ($urandom_range(20, 60)) begin
				@(negedge clk);
				case (mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
					default:   out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// result monitor
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check(cp_result_t'({code_point, is_replacement, run_last, string_done}));
		end
	end

	// watchdog on cycles with no request accepted on either side
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("utf8_stream_decoder_tb: done, errors");
		$finish;
	end

endmodule

// File: files.f
src/u8sd_pkg.sv
src/u8sd_ctrl.sv
src/u8sd_dpath.sv
src/utf8_stream_decoder.sv
dv/utf8_stream_decoder_tb.sv
